// ===== rtl/qaa_pkg.sv =====
package qaa_pkg;

    localparam int CompW       = 16;
    localparam int FracW       = CompW - 1;
    localparam int SqW         = 2 * CompW - 1;
    localparam int SumW        = 2 * CompW;
    localparam int RootW       = CompW;
    localparam int RemW        = RootW + 4;
    localparam int SqrtSteps   = RootW;
    localparam int DenW        = RootW + 1;
    localparam int DivSteps    = CompW;
    localparam int CordicSteps = 31;
    localparam int CordW       = 36;
    localparam int AccW        = 34;
    localparam int AngleW      = 16;
    localparam int ThrW        = 15;
    localparam int Lanes       = 3;

    localparam logic [AngleW-1:0]      AngleMax  = 16'd51472;
    localparam logic signed [AccW-1:0] HalfPiQ30 = 34'sd1686629713;

    // arctangent of 2^-i in 2^-30 rad units
    function automatic logic signed [AccW-1:0] atan_step(input int i);
        logic signed [AccW-1:0] r;
        case (i)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043837;
            3:       r = 34'sd133525159;
            4:       r = 34'sd67021687;
            5:       r = 34'sd33543516;
            6:       r = 34'sd16775851;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194283;
            9:       r = 34'sd2097149;
            default: r = 34'sd1 <<< (30 - i);
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic signed [CompW-1:0] x;
        logic signed [CompW-1:0] y;
        logic signed [CompW-1:0] z;
        logic signed [CompW-1:0] w;
        logic [SqW-1:0]          sqx;
        logic [SqW-1:0]          sqy;
        logic [SqW-1:0]          sqz;
        logic [SqW-1:0]          sqw;
    } t_sq_stg;

    typedef struct packed {
        logic signed [CompW-1:0] x;
        logic signed [CompW-1:0] y;
        logic signed [CompW-1:0] z;
        logic signed [CompW-1:0] w;
        logic [SumW-1:0]         lval;
        logic [RemW-1:0]         lrem;
        logic [RootW-1:0]        lroot;
        logic [SumW-1:0]         sval;
        logic [RemW-1:0]         srem;
        logic [RootW-1:0]        sroot;
    } t_rt_stg;

    typedef struct packed {
        logic                                degen;
        logic [Lanes-1:0]                    neg;
        logic [DenW-1:0]                     den;
        logic [Lanes-1:0][DenW-1:0]          drem;
        logic [Lanes-1:0][CompW-1:0]         dlow;
        logic [Lanes-1:0][CompW-1:0]         dq;
        logic signed [CordW-1:0]             cx;
        logic signed [CordW-1:0]             cy;
        logic signed [AccW-1:0]              acc;
    } t_cd_stg;

endpackage

// ===== rtl/quaternion_to_axis_angle.sv =====
// Quaternion to axis-angle converter. One quaternion (x, y, z, w, signed Q1.15) enters per
// cycle and one result leaves per cycle while the output is not held. There are stages for
// the squares and sums, the two square roots (one root bit a stage) and the threshold
// test and set-up, then thirty-one CORDIC vectoring stages for the arccosine (the axis
// divisions run alongside in the first sixteen of them) and one output register. The whole
// pipeline holds while a result waits at the output. When the vector length is at or below
// zero_threshold the result is axis (0, 0, 32767), angle 0, with the degenerate flag set.
module quaternion_to_axis_angle
    import qaa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ThrW-1:0]     i_cfg_wr_data,     // zero_threshold
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [4*CompW-1:0]  i_s_axis_tdata,    // quat_x, quat_y, quat_z, quat_w
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [3*CompW+AngleW-1:0] o_m_axis_tdata, // axis_x, axis_y, axis_z, angle
    output logic [0:0]          o_m_axis_tuser     // degenerate
);

    logic              en;
    logic [ThrW-1:0]   r_thr;
    logic              r_vld0;
    t_sq_stg           r_sq;
    logic [SqrtSteps:0] r_rvld;
    t_rt_stg           r_rt [SqrtSteps+1];
    logic [CordicSteps:0] r_cvld;
    t_cd_stg           r_cd [CordicSteps+1];
    logic              r_out_vld;

    assign en              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ThrW'(1);
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0    <= 1'b0;
            r_rvld    <= '0;
            r_cvld    <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld0    <= i_s_axis_tvalid;
            r_rvld    <= {r_rvld[SqrtSteps-1:0], r_vld0};
            r_cvld    <= {r_cvld[CordicSteps-1:0], r_rvld[SqrtSteps]};
            r_out_vld <= r_cvld[CordicSteps];
        end
    end

    // squares
    always_ff @(posedge i_clk) begin
        logic signed [CompW-1:0]   x, y, z, w;
        logic signed [2*CompW-1:0] px, py, pz, pw;
        if (en) begin
            x  = i_s_axis_tdata[0*CompW +: CompW];
            y  = i_s_axis_tdata[1*CompW +: CompW];
            z  = i_s_axis_tdata[2*CompW +: CompW];
            w  = i_s_axis_tdata[3*CompW +: CompW];
            px = x * x;
            py = y * y;
            pz = z * z;
            pw = w * w;
            r_sq.x   <= x;
            r_sq.y   <= y;
            r_sq.z   <= z;
            r_sq.w   <= w;
            r_sq.sqx <= px[SqW-1:0];
            r_sq.sqy <= py[SqW-1:0];
            r_sq.sqz <= pz[SqW-1:0];
            r_sq.sqw <= pw[SqW-1:0];
        end
    end

    // sum of squares and 1 - w^2
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt[0].x     <= r_sq.x;
            r_rt[0].y     <= r_sq.y;
            r_rt[0].z     <= r_sq.z;
            r_rt[0].w     <= r_sq.w;
            r_rt[0].lval  <= SumW'(r_sq.sqx) + SumW'(r_sq.sqy) + SumW'(r_sq.sqz);
            r_rt[0].lrem  <= '0;
            r_rt[0].lroot <= '0;
            r_rt[0].sval  <= (SumW'(1) << (2 * FracW)) - SumW'(r_sq.sqw);
            r_rt[0].srem  <= '0;
            r_rt[0].sroot <= '0;
        end
    end

    function automatic logic [RemW+RootW-1:0] sqrt_step(input logic [RemW-1:0] rem,
                                                        input logic [RootW-1:0] root,
                                                        input logic [1:0] pair);
        logic [RemW-1:0] t;
        logic [RemW-1:0] trial;
        t     = {rem[RemW-3:0], pair};
        trial = RemW'({root, 2'b01});
        if (t >= trial) begin
            return {t - trial, root[RootW-2:0], 1'b1};
        end
        return {t, root[RootW-2:0], 1'b0};
    endfunction

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rt[k+1].x <= r_rt[k].x;
                r_rt[k+1].y <= r_rt[k].y;
                r_rt[k+1].z <= r_rt[k].z;
                r_rt[k+1].w <= r_rt[k].w;
                {r_rt[k+1].lrem, r_rt[k+1].lroot} <=
                    sqrt_step(r_rt[k].lrem, r_rt[k].lroot, r_rt[k].lval[SumW-1 -: 2]);
                {r_rt[k+1].srem, r_rt[k+1].sroot} <=
                    sqrt_step(r_rt[k].srem, r_rt[k].sroot, r_rt[k].sval[SumW-1 -: 2]);
                r_rt[k+1].lval <= {r_rt[k].lval[SumW-3:0], 2'b00};
                r_rt[k+1].sval <= {r_rt[k].sval[SumW-3:0], 2'b00};
            end
        end
    end

    // threshold test, division and CORDIC set-up
    always_ff @(posedge i_clk) begin
        logic [RootW-1:0]        len;
        logic signed [CompW-1:0] c [Lanes];
        logic [CompW-1:0]        mag;
        logic [SumW-1:0]         num;
        logic signed [CordW-1:0] xw, ys;
        if (en) begin
            len  = r_rt[SqrtSteps].lroot;
            c[0] = r_rt[SqrtSteps].x;
            c[1] = r_rt[SqrtSteps].y;
            c[2] = r_rt[SqrtSteps].z;
            r_cd[0].degen <= len <= RootW'(r_thr);
            r_cd[0].den   <= {len, 1'b0};
            for (int l = 0; l < Lanes; l++) begin
                mag = c[l][CompW-1] ? CompW'(-c[l]) : CompW'(c[l]);
                num = {mag, {CompW{1'b0}}} + SumW'(len);
                r_cd[0].neg[l]  <= c[l][CompW-1];
                r_cd[0].drem[l] <= DenW'(num[SumW-1 -: CompW]);
                r_cd[0].dlow[l] <= num[CompW-1:0];
                r_cd[0].dq[l]   <= '0;
            end
            xw = CordW'(r_rt[SqrtSteps].w) <<< (31 - FracW);
            ys = CordW'(r_rt[SqrtSteps].sroot) <<< (31 - FracW);
            // rotate a vector in the left half-plane by -pi/2 first
            if (r_rt[SqrtSteps].w[CompW-1]) begin
                r_cd[0].cx  <= ys;
                r_cd[0].cy  <= -xw;
                r_cd[0].acc <= HalfPiQ30;
            end else begin
                r_cd[0].cx  <= xw;
                r_cd[0].cy  <= ys;
                r_cd[0].acc <= '0;
            end
        end
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            logic signed [CordW-1:0] dx, dy;
            logic [DenW:0]           t;
            if (en) begin
                dx = r_cd[i].cy >>> i;
                dy = r_cd[i].cx >>> i;
                if (r_cd[i].cy > 0) begin
                    r_cd[i+1].cx  <= r_cd[i].cx + dx;
                    r_cd[i+1].cy  <= r_cd[i].cy - dy;
                    r_cd[i+1].acc <= r_cd[i].acc + atan_step(i);
                end else begin
                    r_cd[i+1].cx  <= r_cd[i].cx - dx;
                    r_cd[i+1].cy  <= r_cd[i].cy + dy;
                    r_cd[i+1].acc <= r_cd[i].acc - atan_step(i);
                end
                r_cd[i+1].degen <= r_cd[i].degen;
                r_cd[i+1].neg   <= r_cd[i].neg;
                r_cd[i+1].den   <= r_cd[i].den;
                for (int l = 0; l < Lanes; l++) begin
                    if (i < DivSteps) begin
                        t = {r_cd[i].drem[l], r_cd[i].dlow[l][CompW-1]};
                        if (t >= {1'b0, r_cd[i].den}) begin
                            r_cd[i+1].drem[l] <= DenW'(t - {1'b0, r_cd[i].den});
                            r_cd[i+1].dq[l]   <= {r_cd[i].dq[l][CompW-2:0], 1'b1};
                        end else begin
                            r_cd[i+1].drem[l] <= DenW'(t);
                            r_cd[i+1].dq[l]   <= {r_cd[i].dq[l][CompW-2:0], 1'b0};
                        end
                        r_cd[i+1].dlow[l] <= {r_cd[i].dlow[l][CompW-2:0], 1'b0};
                    end else begin
                        r_cd[i+1].drem[l] <= r_cd[i].drem[l];
                        r_cd[i+1].dq[l]   <= r_cd[i].dq[l];
                        r_cd[i+1].dlow[l] <= r_cd[i].dlow[l];
                    end
                end
            end
        end
    end

    // round, clamp and saturate into the output register
    always_ff @(posedge i_clk) begin
        logic signed [AccW-1:0] acc;
        logic [AccW-1:0]        rnd;
        logic [AngleW-1:0]      ang;
        logic [CompW-1:0]       q;
        logic [CompW-1:0]       ax [Lanes];
        if (en) begin
            acc = r_cd[CordicSteps].acc;
            if (acc < 0) begin
                acc = '0;
            end
            rnd = ($unsigned(acc) + (AccW'(1) << 15)) >> 16;
            ang = (rnd > AccW'(AngleMax)) ? AngleMax : rnd[AngleW-1:0];
            for (int l = 0; l < Lanes; l++) begin
                q = r_cd[CordicSteps].dq[l];
                if (r_cd[CordicSteps].neg[l]) begin
                    ax[l] = -q;
                end else if (q[CompW-1]) begin
                    ax[l] = {1'b0, {(CompW-1){1'b1}}};
                end else begin
                    ax[l] = q;
                end
            end
            if (r_cd[CordicSteps].degen) begin
                o_m_axis_tdata <= {AngleW'(0), 1'b0, {(CompW-1){1'b1}},
                                   CompW'(0), CompW'(0)};
                o_m_axis_tuser <= 1'b1;
            end else begin
                o_m_axis_tdata <= {ang, ax[2], ax[1], ax[0]};
                o_m_axis_tuser <= 1'b0;
            end
        end
    end

endmodule
